[src/silence_region_detector_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the silence region detector
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SILENCE_REGION_DETECTOR_UNIT_ASSERT_SVH
`define SILENCE_REGION_DETECTOR_UNIT_ASSERT_SVH

// Property checked on every rising edge while reset is released.
`define SRD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define SRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/srd_pkg.sv]
// ----------------------------------------------------------------------------
// Silence region detector package
// Widths, register codes, reset values and shared types of the detector.
// ----------------------------------------------------------------------------
package srd_pkg;

    // Field and register widths.
    localparam int SAMPLE_BITS  = 24;
    localparam int INDEX_BITS   = 32;
    localparam int CFG_BITS     = 24;
    localparam int OUT_BITS     = 32;
    localparam int CFG_IDX_BITS = 2;

    // Compare widths that cover both operands.
    localparam int MAG_CMP_BITS = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
    localparam int LEN_CMP_BITS = (INDEX_BITS > CFG_BITS) ? INDEX_BITS : CFG_BITS;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_SILENCE_LEVEL = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_RUN       = CFG_IDX_BITS'(1);

    // Register reset values: about -60 dBFS and 0.1 s at 48 kHz.
    localparam logic [CFG_BITS-1:0] SILENCE_LEVEL_RST = CFG_BITS'(8389);
    localparam logic [CFG_BITS-1:0] MIN_RUN_RST       = CFG_BITS'(4800);

    // Largest sample index; the counter saturates here.
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

    // One input item.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [OUT_BITS-1:0] region_start;
        logic [OUT_BITS-1:0] region_end;
        logic [OUT_BITS-1:0] region_length;
        logic                ended_by_buffer_end;
    } t_result;

    // Configuration seen by the run tracker.
    typedef struct packed {
        logic [CFG_BITS-1:0] silence_level;
        logic [CFG_BITS-1:0] min_run_samples;
    } t_cfg;

endpackage

[src/srd_input_stage.sv]
// ----------------------------------------------------------------------------
// Silence region detector input stage
// Registers one incoming item and holds it until the tracker consumes it.
// ----------------------------------------------------------------------------
module srd_input_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  srd_pkg::t_item i_item,
    input  logic          i_advance,
    output logic          o_item_valid,
    output srd_pkg::t_item o_item
);

    logic           r_valid;
    srd_pkg::t_item r_item;
    logic           w_load;

    // The register frees up in the same cycle its item moves on.
    assign o_ready = !r_valid || i_advance;
    assign w_load  = i_valid && o_ready;

    // Valid flag of the held item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

[src/srd_run_tracker.sv]
// ----------------------------------------------------------------------------
// Silence region detector run tracker
// Classifies a sample, updates the run state and forms the result item.
// ----------------------------------------------------------------------------
module srd_run_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  srd_pkg::t_cfg    i_cfg,
    input  srd_pkg::t_item   i_item,
    input  logic             i_step,
    output logic             o_emit,
    output srd_pkg::t_result o_result
);

    logic                               r_inside;
    logic [srd_pkg::INDEX_BITS-1:0]     r_begin;
    logic [srd_pkg::INDEX_BITS-1:0]     r_index;
    logic                               n_inside;
    logic [srd_pkg::INDEX_BITS-1:0]     n_begin;
    logic [srd_pkg::INDEX_BITS-1:0]     n_index;

    logic [srd_pkg::SAMPLE_BITS-1:0]    w_raw;
    logic [srd_pkg::SAMPLE_BITS-1:0]    w_mag;
    logic                               w_silent;
    logic [srd_pkg::INDEX_BITS-1:0]     w_index_next;
    logic                               w_inside_upd;
    logic [srd_pkg::INDEX_BITS-1:0]     w_begin_upd;
    logic [srd_pkg::INDEX_BITS-1:0]     w_end;
    logic [srd_pkg::INDEX_BITS-1:0]     w_len;
    logic                               w_by_end;

    // Magnitude; the most negative sample negates to itself, which read
    // unsigned is exactly its magnitude.
    assign w_raw    = i_item.sample;
    assign w_mag    = w_raw[srd_pkg::SAMPLE_BITS-1] ? (~w_raw + 1'b1) : w_raw;
    assign w_silent = srd_pkg::MAG_CMP_BITS'(w_mag)
                    < srd_pkg::MAG_CMP_BITS'(i_cfg.silence_level);

    // Saturating index increment.
    assign w_index_next = (r_index == srd_pkg::INDEX_MAX) ? r_index : r_index + 1'b1;

    // Run update and result selection for the item at the tracker input.
    always_comb begin
        w_inside_upd = r_inside;
        w_begin_upd  = r_begin;
        w_end        = r_index;
        w_by_end     = 1'b0;
        o_emit       = 1'b0;
        n_inside     = r_inside;
        n_begin      = r_begin;
        n_index      = r_index;

        if (w_silent && !r_inside) begin
            // A silent run opens at this sample.
            w_inside_upd = 1'b1;
            w_begin_upd  = r_index;
        end else if (!w_silent && r_inside) begin
            // A loud sample closes the run.
            w_inside_upd = 1'b0;
            w_end        = r_index;
            o_emit       = srd_pkg::LEN_CMP_BITS'(r_index - r_begin)
                         > srd_pkg::LEN_CMP_BITS'(i_cfg.min_run_samples);
        end

        if (i_item.last_sample) begin
            // Buffer end closes a trailing run, then all state clears.
            if (w_inside_upd) begin
                w_end    = w_index_next;
                w_by_end = 1'b1;
                o_emit   = srd_pkg::LEN_CMP_BITS'(w_index_next - w_begin_upd)
                         > srd_pkg::LEN_CMP_BITS'(i_cfg.min_run_samples);
            end
            n_inside = 1'b0;
            n_begin  = '0;
            n_index  = '0;
        end else begin
            n_inside = w_inside_upd;
            n_begin  = w_begin_upd;
            n_index  = w_index_next;
        end
    end

    assign w_len = w_end - w_begin_upd;

    assign o_result.region_start        = srd_pkg::OUT_BITS'(w_begin_upd);
    assign o_result.region_end          = srd_pkg::OUT_BITS'(w_end);
    assign o_result.region_length       = srd_pkg::OUT_BITS'(w_len);
    assign o_result.ended_by_buffer_end = w_by_end;

    // Run state advances once per consumed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_begin  <= '0;
            r_index  <= '0;
        end else if (i_step) begin
            r_inside <= n_inside;
            r_begin  <= n_begin;
            r_index  <= n_index;
        end
    end

endmodule

[src/srd_result_reg.sv]
// ----------------------------------------------------------------------------
// Silence region detector result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module srd_result_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  srd_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output srd_pkg::t_result o_result
);

    logic             r_valid;
    srd_pkg::t_result r_result;

    // Valid flag: set on load, cleared when the item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[src/silence_region_detector_unit.sv]
// ----------------------------------------------------------------------------
// Silence region detector
// Finds runs of quiet samples in a mono stream and reports long ones.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the i_valid / o_ready channel, one signed Q1.23 sample per
// item with i_last_sample marking the final sample of a buffer. Each sample
// gives zero or one result item on the o_valid / i_ready channel: start,
// exclusive end and length of a silent run, plus a flag telling whether the
// buffer end closed it.
// An accepted item sits in the input register, and the run tracker writes its
// result into the result register as the item moves on.
// Throughput is one item per cycle; the single compare and index update
// between the input register and the result register set that figure.
// When the receiver stalls with a result pending, an item that would give a
// new result waits in the input register and o_ready drops; items that give
// no result keep flowing.
// Reset (synchronous, active low) clears the run state and both valid flags
// and restores silence_level to 8389 and min_run_samples to 4800.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_wdata by the user
// only while the block is idle, which the block itself does not enforce;
// indexes beyond the list are ignored.
// ----------------------------------------------------------------------------
module silence_region_detector_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [srd_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [srd_pkg::CFG_BITS-1:0]         i_cfg_wdata,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [srd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                 i_last_sample,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [srd_pkg::OUT_BITS-1:0]         o_region_start,
    output logic [srd_pkg::OUT_BITS-1:0]         o_region_end,
    output logic [srd_pkg::OUT_BITS-1:0]         o_region_length,
    output logic                                 o_ended_by_buffer_end
);

    srd_pkg::t_cfg    r_cfg;
    srd_pkg::t_item   w_in_item;
    srd_pkg::t_item   w_held_item;
    logic             w_held_valid;
    logic             w_emit;
    logic             w_advance;
    srd_pkg::t_result w_result;
    srd_pkg::t_result w_out_result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.silence_level   <= srd_pkg::SILENCE_LEVEL_RST;
            r_cfg.min_run_samples <= srd_pkg::MIN_RUN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                srd_pkg::REG_SILENCE_LEVEL: r_cfg.silence_level   <= i_cfg_wdata;
                srd_pkg::REG_MIN_RUN:       r_cfg.min_run_samples <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_in_item.sample      = i_sample;
    assign w_in_item.last_sample = i_last_sample;

    // The held item moves on unless it has a result and the output is blocked.
    assign w_advance = w_held_valid && (!w_emit || !o_valid || i_ready);

    srd_input_stage u_input (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (w_in_item),
        .i_advance    (w_advance),
        .o_item_valid (w_held_valid),
        .o_item       (w_held_item)
    );

    srd_run_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (w_held_item),
        .i_step   (w_advance),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    srd_result_reg u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_emit),
        .i_result (w_result),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_result (w_out_result)
    );

    assign o_region_start        = w_out_result.region_start;
    assign o_region_end          = w_out_result.region_end;
    assign o_region_length       = w_out_result.region_length;
    assign o_ended_by_buffer_end = w_out_result.ended_by_buffer_end;

endmodule

[src/srd_checker.sv]
// ----------------------------------------------------------------------------
// Silence region detector port checker
// Watches the top-level ports and flags behavior that breaks the contract.
// ----------------------------------------------------------------------------
`include "silence_region_detector_unit_assert.svh"

module srd_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_cfg_we,
    input logic [srd_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input logic [srd_pkg::CFG_BITS-1:0]           i_cfg_wdata,
    input logic                                   i_valid,
    input logic                                   o_ready,
    input logic signed [srd_pkg::SAMPLE_BITS-1:0] i_sample,
    input logic                                   i_last_sample,
    input logic                                   o_valid,
    input logic                                   i_ready,
    input logic [srd_pkg::OUT_BITS-1:0]           o_region_start,
    input logic [srd_pkg::OUT_BITS-1:0]           o_region_end,
    input logic [srd_pkg::OUT_BITS-1:0]           o_region_length,
    input logic                                   o_ended_by_buffer_end
);

    // A stalled result item keeps its valid and its payload.
    `SRD_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_region_start) && $stable(o_region_end) && $stable(o_region_length) && $stable(o_ended_by_buffer_end), "result item changed while stalled")

    // The reported length always matches the reported bounds.
    `SRD_ASSERT(a_len_match, i_clk, i_rst_n, o_valid |-> o_region_length == o_region_end - o_region_start, "region length does not match its bounds")

    // No result item is offered in the cycle after reset.
    `SRD_ASSERT_ALWAYS(a_rst_quiet, i_clk, !$past(i_rst_n) && i_rst_n |-> !o_valid, "result valid right after reset")

endmodule

bind silence_region_detector_unit srd_checker u_srd_checker (.*);

[verif/tb_silence_region_detector_unit.sv]
// ----------------------------------------------------------------------------
// Testbench for the silence region detector
// Streams samples with random pacing on both handshakes and predicts every
// silent region from its own run tracker. Each region that arrives is compared
// field by field with the oldest prediction. Phases cover level boundaries,
// full-scale and most-negative samples, the minimum run length, ignored
// register writes, structured buffers under several settings, a long output
// stall and raw noise.
// ----------------------------------------------------------------------------
module tb_silence_region_detector_unit;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int IDLE_PCT      = 21;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int RUN_LIMIT     = 200000;
    localparam int PRINT_LIMIT   = 40;
    localparam int SBITS         = srd_pkg::SAMPLE_BITS;
    localparam int CBITS         = srd_pkg::CFG_BITS;
    localparam int IBITS         = srd_pkg::INDEX_BITS;
    localparam int XBITS         = srd_pkg::CFG_IDX_BITS;
    localparam int FULL_SCALE    = 2 ** (SBITS - 1);
    localparam int unsigned MIN_RUN_TOP = 2 ** CBITS - 1;
    localparam int LEVEL_RST     = int'(srd_pkg::SILENCE_LEVEL_RST);

    // Register indexes past the end of the list; writes there do nothing.
    localparam logic [XBITS-1:0] REG_SPARE_A = XBITS'(2);
    localparam logic [XBITS-1:0] REG_SPARE_B = XBITS'(3);

    // Block ports.
    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_we      = 1'b0;
    logic [XBITS-1:0]              i_cfg_idx     = srd_pkg::REG_SILENCE_LEVEL;
    logic [CBITS-1:0]              i_cfg_wdata   = '0;
    logic                          i_valid       = 1'b0;
    logic                          o_ready;
    logic signed [SBITS-1:0]       i_sample      = '0;
    logic                          i_last_sample = 1'b0;
    logic                          o_valid;
    logic                          i_ready       = 1'b0;
    logic [srd_pkg::OUT_BITS-1:0]  o_region_start;
    logic [srd_pkg::OUT_BITS-1:0]  o_region_end;
    logic [srd_pkg::OUT_BITS-1:0]  o_region_length;
    logic                          o_ended_by_buffer_end;

    // Predicted run state and register copies.
    logic             in_run        = 1'b0;
    logic [IBITS-1:0] run_start_idx = '0;
    logic [IBITS-1:0] next_idx      = '0;
    logic [CBITS-1:0] level_reg     = srd_pkg::SILENCE_LEVEL_RST;
    logic [CBITS-1:0] min_run_reg   = srd_pkg::MIN_RUN_RST;

    srd_pkg::t_result expected_regions[$];
    srd_pkg::t_result seen_region;
    int unsigned      error_count = 0;
    int unsigned      cycle_count = 0;
    int unsigned      hold_left   = 0;
    bit               steady      = 1'b0;

    silence_region_detector_unit u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_sample              (i_sample),
        .i_last_sample         (i_last_sample),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_region_start        (o_region_start),
        .o_region_end          (o_region_end),
        .o_region_length       (o_region_length),
        .o_ended_by_buffer_end (o_ended_by_buffer_end)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("tb_silence_region_detector_unit: errors");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic srd_pkg::t_result region_of(input logic [IBITS-1:0] first,
                                                   input logic [IBITS-1:0] stop,
                                                   input logic by_end);
        srd_pkg::t_result r;
        r.region_start        = first;
        r.region_end          = stop;
        r.region_length       = stop - first;
        r.ended_by_buffer_end = by_end;
        return r;
    endfunction

    // Append one predicted region at the back of the queue.
    function automatic void queue_region(input srd_pkg::t_result r);
        expected_regions.insert(expected_regions.size(), r);
    endfunction

    // Advance the run tracker by one sample and queue the region it closes.
    function automatic void track_silence(input logic signed [SBITS-1:0] s,
                                          input logic last);
        int               value;
        int               mag;
        logic             quiet;
        logic [IBITS-1:0] idx;
        logic [IBITS-1:0] stop;
        value = s;
        mag   = (value < 0) ? -value : value;
        quiet = mag < int'(level_reg);
        idx   = next_idx;
        if (quiet && !in_run) begin
            run_start_idx = idx;
            in_run        = 1'b1;
        end else if (!quiet && in_run) begin
            if (idx - run_start_idx > IBITS'(min_run_reg))
                queue_region(region_of(run_start_idx, idx, 1'b0));
            in_run = 1'b0;
        end
        // A silent flagged sample closes the trailing run one index later.
        if (last) begin
            if (in_run) begin
                stop = (idx == srd_pkg::INDEX_MAX) ? srd_pkg::INDEX_MAX : idx + 1;
                if (stop - run_start_idx > IBITS'(min_run_reg))
                    queue_region(region_of(run_start_idx, stop, 1'b1));
            end
            in_run        = 1'b0;
            run_start_idx = '0;
            next_idx      = '0;
        end else begin
            next_idx = (idx == srd_pkg::INDEX_MAX) ? srd_pkg::INDEX_MAX : idx + 1;
        end
    endfunction

    // Receiver: random stalls, a steady mode and a counted hold-off.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (steady) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each accepted region with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_regions.size() == 0) begin
                report_error($sformatf("unexpected region start=%0d end=%0d",
                                       o_region_start, o_region_end));
            end else begin
                seen_region = expected_regions.pop_front();
                if (o_region_start !== seen_region.region_start)
                    report_error($sformatf("region_start %0d, expected %0d",
                                           o_region_start, seen_region.region_start));
                if (o_region_end !== seen_region.region_end)
                    report_error($sformatf("region_end %0d, expected %0d",
                                           o_region_end, seen_region.region_end));
                if (o_region_length !== seen_region.region_length)
                    report_error($sformatf("region_length %0d, expected %0d",
                                           o_region_length, seen_region.region_length));
                if (o_ended_by_buffer_end !== seen_region.ended_by_buffer_end)
                    report_error($sformatf("ended_by_buffer_end %0b, expected %0b",
                                           o_ended_by_buffer_end,
                                           seen_region.ended_by_buffer_end));
            end
        end
    end

    // Send one sample item; returns at the edge where it was accepted.
    task automatic send_sample(input logic signed [SBITS-1:0] s, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample      <= s;
        i_last_sample <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        track_silence(s, last);
    endtask

    // Stop offering items, drain all regions, then let the pipeline empty.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_regions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_register(input logic [XBITS-1:0] idx,
                                    input int unsigned value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= CBITS'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == srd_pkg::REG_SILENCE_LEVEL)
            level_reg = CBITS'(value);
        else if (idx == srd_pkg::REG_MIN_RUN)
            min_run_reg = CBITS'(value);
    endtask

    task automatic apply_setting(input int unsigned level, input int unsigned min_run);
        program_register(srd_pkg::REG_SILENCE_LEVEL, level);
        program_register(srd_pkg::REG_MIN_RUN, min_run);
    endtask

    // Pick a quiet or loud sample for the current level, often at its edge.
    function automatic logic signed [SBITS-1:0] pick_sample(input bit want_quiet);
        int unsigned lvl;
        int unsigned lo;
        int unsigned hi;
        int unsigned mag;
        lvl = level_reg;
        if (want_quiet && lvl != 0) begin
            lo = 0;
            hi = (lvl - 1 > FULL_SCALE) ? FULL_SCALE : lvl - 1;
        end else if (!want_quiet && lvl <= FULL_SCALE) begin
            lo = lvl;
            hi = FULL_SCALE;
        end else begin
            return SBITS'($urandom);
        end
        case ($urandom_range(3))
            0: mag = lo;
            1: mag = hi;
            default: mag = $urandom_range(hi, lo);
        endcase
        if (mag == FULL_SCALE)
            return {1'b1, {(SBITS-1){1'b0}}};
        return $urandom_range(1) ? -SBITS'(mag) : SBITS'(mag);
    endfunction

    // Buffers made of alternating quiet and loud stretches, with some noise,
    // stray end flags and buffers that run on without one.
    task automatic run_buffers(input int n_items, input int max_seg);
        int                      sent;
        int                      buf_len;
        int                      seg_left;
        bit                      quiet;
        bit                      flag_last;
        logic signed [SBITS-1:0] s;
        sent = 0;
        while (sent < n_items) begin
            buf_len  = $urandom_range(60, 1);
            seg_left = 0;
            quiet    = $urandom_range(1);
            for (int k = 0; k < buf_len; k++) begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(max_seg, 1);
                    quiet    = !quiet;
                end
                seg_left--;
                s = ($urandom_range(15) == 0) ? SBITS'($urandom) : pick_sample(quiet);
                flag_last = ((k == buf_len - 1) && ($urandom_range(7) != 0))
                            || ($urandom_range(31) == 0);
                send_sample(s, flag_last);
                sent++;
            end
        end
    endtask

    // The reset level sits right between 8388 and 8389 in magnitude.
    task automatic test_reset_level();
        program_register(srd_pkg::REG_MIN_RUN, 0);
        send_sample(SBITS'(LEVEL_RST - 1), 1'b0);
        send_sample(SBITS'(1 - LEVEL_RST), 1'b0);
        send_sample(SBITS'(LEVEL_RST), 1'b0);
        send_sample(SBITS'(-LEVEL_RST), 1'b0);
        send_sample(SBITS'(0), 1'b1);
    endtask

    // Full-scale and most-negative samples, a loud flagged sample inside a
    // run, a one-sample buffer and a level at which nothing is silent.
    task automatic test_field_extremes();
        apply_setting(FULL_SCALE, 0);
        send_sample(SBITS'(FULL_SCALE - 1), 1'b0);
        send_sample(SBITS'(1 - FULL_SCALE), 1'b0);
        send_sample(SBITS'(-FULL_SCALE), 1'b0);
        send_sample(SBITS'(0), 1'b1);
        program_register(srd_pkg::REG_SILENCE_LEVEL, 100);
        send_sample(SBITS'(FULL_SCALE - 1), 1'b0);
        send_sample(SBITS'(-FULL_SCALE), 1'b0);
        send_sample(SBITS'(0), 1'b0);
        send_sample(SBITS'(0), 1'b0);
        send_sample(SBITS'(FULL_SCALE - 1), 1'b1);
        send_sample(SBITS'(0), 1'b1);
        program_register(srd_pkg::REG_SILENCE_LEVEL, 0);
        send_sample(SBITS'(0), 1'b1);
    endtask

    // A run as long as the minimum is dropped; one sample longer is reported.
    task automatic test_min_run_limits();
        apply_setting(100, 2);
        send_sample(SBITS'(3), 1'b0);
        send_sample(SBITS'(-3), 1'b0);
        send_sample(SBITS'(500), 1'b0);
        send_sample(SBITS'(99), 1'b0);
        send_sample(SBITS'(-99), 1'b0);
        send_sample(SBITS'(0), 1'b0);
        send_sample(SBITS'(-100), 1'b0);
    endtask

    // Writes past the register list must leave both registers alone.
    task automatic test_ignored_writes();
        apply_setting(100, 0);
        program_register(REG_SPARE_A, 0);
        program_register(REG_SPARE_B, MIN_RUN_TOP);
        send_sample(SBITS'(50), 1'b0);
        send_sample(SBITS'(200), 1'b1);
    endtask

    task automatic test_random_settings();
        apply_setting(100, 0);
        run_buffers(180, 8);
        apply_setting(FULL_SCALE, 3);
        run_buffers(180, 10);
        apply_setting(1, 0);
        run_buffers(180, 6);
        apply_setting(0, 0);
        run_buffers(120, 6);
        apply_setting(5000, MIN_RUN_TOP);
        run_buffers(120, 8);
        repeat (2) begin
            apply_setting($urandom_range(FULL_SCALE, 1), $urandom_range(6));
            run_buffers(180, 8);
        end
    endtask

    // Back-to-back items on both sides with no idling at all.
    task automatic test_steady_stream();
        steady <= 1'b1;
        apply_setting(2000, 1);
        run_buffers(200, 8);
        wait_idle();
        steady <= 1'b0;
    endtask

    // Receiver holds off while short runs keep producing regions.
    task automatic test_output_backpressure();
        apply_setting(300, 0);
        hold_left <= HOLD_CYCLES;
        run_buffers(200, 2);
    endtask

    task automatic test_noise();
        apply_setting($urandom_range(FULL_SCALE, 1), $urandom_range(4));
        repeat (100) send_sample(SBITS'($urandom), ($urandom_range(15) == 0));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_level();
        test_field_extremes();
        test_min_run_limits();
        test_ignored_writes();
        test_random_settings();
        test_steady_stream();
        test_output_backpressure();
        test_noise();
        wait_idle();
        if (error_count == 0)
            $display("tb_silence_region_detector_unit: clean");
        else
            $display("tb_silence_region_detector_unit: errors");
        $finish;
    end

endmodule
